// ===== hw/rtl/leb128_varint_encoder_core_defines.svh =====
`ifndef LEB128_VARINT_ENCODER_CORE_DEFINES_SVH
`define LEB128_VARINT_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LEB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LEB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/leb_pkg.sv =====
package leb_pkg;

  localparam int unsigned GROUP_BITS = 7;
  localparam int unsigned MAX_BYTES  = 10;
  localparam int unsigned CNT_W      = $clog2(MAX_BYTES);

  // microcode program: two steps
  localparam int unsigned STEP_W = 1;
  localparam logic [STEP_W-1:0] STEP_ACCEPT = 1'b0;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 1'b1;

  // jump condition of a control word
  typedef enum logic [0:0] {
    COND_IN_BEAT   = 1'b0,
    COND_LAST_BEAT = 1'b1
  } cond_e;

  typedef struct packed {
    logic              take_in;
    logic              emit;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_beat;
    logic last_beat;
  } sts_t;

  function automatic ctrl_t leb_rom(input logic [STEP_W-1:0] step);
    ctrl_t cw;
    unique case (step)
      STEP_ACCEPT: cw = '{take_in: 1'b1, emit: 1'b0, cond: COND_IN_BEAT,
                          target: STEP_EMIT};
      STEP_EMIT:   cw = '{take_in: 1'b0, emit: 1'b1, cond: COND_LAST_BEAT,
                          target: STEP_ACCEPT};
    endcase
    return cw;
  endfunction

endpackage

// ===== hw/rtl/leb_seq.sv =====
module leb_seq import leb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  sts_t  sts_i,
  output ctrl_t ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic              jump;

  assign ctrl_o = leb_rom(step_q);

  // jump to target on condition, else hold the step
  always_comb begin
    unique case (ctrl_o.cond)
      COND_IN_BEAT:   jump = sts_i.in_beat;
      COND_LAST_BEAT: jump = sts_i.last_beat;
    endcase
    step_d = jump ? ctrl_o.target : step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_ACCEPT;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== hw/rtl/leb128_varint_encoder_core.sv =====
// An input beat loads the value and sends the sequencer to the emit step, which
//   fills the output register. A value of n bytes (1..10) leaves one byte a cycle
//   from the emit step unless the output stalls, then the accept step takes the next.
// Reset (rst_ni, async, active low): sequencer at the accept step, no output
//   beat pending. Nothing is kept between values.
module leb128_varint_encoder_core import leb_pkg::*; #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [63:0] value_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  code_byte_o,
  output logic        last_o
);

  // ---------------------------------------------------------------------------
  // Microcode sequencer: step ROM + step counter. The control word tells the
  // datapath whether to take an input beat or emit one byte.
  // ---------------------------------------------------------------------------
  ctrl_t ctrl;
  sts_t  sts;

  leb_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctrl_o (ctrl)
  );

  // ---------------------------------------------------------------------------
  // Datapath: remaining value, mode, byte count, output register.
  // ---------------------------------------------------------------------------
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic                  sgn_q, sgn_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_byte_q, out_byte_d;
  logic                  out_last_q, out_last_d;

  logic                  in_beat;
  logic                  slot_free;
  logic                  emit_beat;
  logic [GROUP_BITS-1:0] grp;
  logic                  fill;
  logic [VALUE_BITS-1:0] shifted;
  logic                  rem_zero;
  logic                  rem_ones;
  logic                  done;

  assign in_stall_o = !ctrl.take_in;
  assign in_beat    = in_valid_i && ctrl.take_in;

  // the output register can take a byte when empty or being drained this cycle
  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit_beat = ctrl.emit && slot_free;

  // low group of the remainder, and the remainder shifted by one group;
  // signed mode shifts arithmetically inside VALUE_BITS, which matches the
  // sign-extended 64-bit value since the upper bits are all copies of the sign
  assign grp      = val_q[GROUP_BITS-1:0];
  assign fill     = sgn_q && val_q[VALUE_BITS-1];
  assign shifted  = {{GROUP_BITS{fill}}, val_q[VALUE_BITS-1:GROUP_BITS]};
  assign rem_zero = (shifted == '0);
  assign rem_ones = (shifted == '1);

  // stop: unsigned when nothing is left; signed when the remainder is pure
  // sign and bit 6 of this byte already carries that sign; hard cap at 10 bytes
  always_comb begin
    if (sgn_q) begin
      done = (rem_zero && !grp[GROUP_BITS-1]) || (rem_ones && grp[GROUP_BITS-1]);
    end else begin
      done = rem_zero;
    end
    if (cnt_q == CNT_W'(MAX_BYTES - 1)) begin
      done = 1'b1;
    end
  end

  assign sts.in_beat   = in_beat;
  assign sts.last_beat = emit_beat && done;

  always_comb begin
    val_d       = val_q;
    sgn_d       = sgn_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (in_beat) begin
      // value bits above VALUE_BITS are dropped here
      val_d = value_i[VALUE_BITS-1:0];
      sgn_d = mode_i;
      cnt_d = '0;
    end
    if (emit_beat) begin
      val_d       = shifted;
      cnt_d       = cnt_q + CNT_W'(1);
      out_valid_d = 1'b1;
      out_byte_d  = {!done, grp};
      out_last_d  = done;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    sgn_q      <= sgn_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_byte_o = out_byte_q;
  assign last_o      = out_last_q;

endmodule

// ===== hw/rtl/leb_chk.sv =====
`include "leb128_varint_encoder_core_defines.svh"

module leb_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  code_byte_o,
  input logic        last_o
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  // continuation bit is the inverse of last on every byte
  `LEB_ASSERT_NOW(a_cont_bit, out_valid_o, code_byte_o[7] != last_o, "cont bit vs last")

  // a new value is never taken right after one was taken
  `LEB_ASSERT_NEXT(a_in_gap, in_beat, in_stall_o, "input taken in emit step")

  // while a non-final byte leaves, the encoder is still mid-value
  `LEB_ASSERT_NOW(a_no_take_mid, out_beat && !last_o, in_stall_o, "input open mid-value")

  // stalled output beat holds
  `LEB_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(code_byte_o) && $stable(last_o),
                   "stalled output changed")

endmodule

bind leb128_varint_encoder_core leb_chk u_leb_chk (.*);
